>>> rtl/box_circle_contact_defines.svh
// assertion macros shared by the box circle contact modules
`ifndef BOX_CIRCLE_CONTACT_DEFINES_SVH
`define BOX_CIRCLE_CONTACT_DEFINES_SVH

// same-cycle implication
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bcc_pkg.sv
// types, constants and step functions for the box circle contact block
package bcc_pkg;

	localparam int SQ_STEPS  = 31;
	localparam int DIV_STEPS = 17;

	localparam logic signed [17:0] NORM_POS  = 18'sh10000;
	localparam logic signed [17:0] NORM_NEG  = 18'sh30000;
	localparam logic signed [17:0] NORM_ZERO = 18'sh00000;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_EDGE,
		CLS_INSIDE
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [29:0]        ax;
		logic [29:0]        ay;
		logic               neg_x;
		logic               neg_y;
		logic [60:0]        s;
		logic [29:0]        r;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic [30:0]        depth;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} ent_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [30:0] root;
	} sq_t;

	typedef struct packed {
		ent_t        pl;
		logic [4:0]  lz;
		logic [29:0] axn;
		logic [29:0] ayn;
		logic [59:0] sqx;
		logic [59:0] sqy;
		logic [60:0] vn;
		sq_t         ra;
		sq_t         rb;
		logic [46:0] nnx;
		logic [46:0] nny;
		logic [30:0] remx;
		logic [30:0] remy;
		logic [16:0] qx;
		logic [16:0] qy;
	} bst_t;

	// one bit of a restoring square root
	function automatic sq_t sq_step(input sq_t a, input logic [1:0] b);
		logic [34:0] r2;
		logic [34:0] t;
		sq_t o;
		r2 = {a.rem, b};
		t  = {2'b00, a.root, 2'b01};
		if (r2 >= t) begin
			o.rem  = 33'(r2 - t);
			o.root = {a.root[29:0], 1'b1};
		end else begin
			o.rem  = r2[32:0];
			o.root = {a.root[29:0], 1'b0};
		end
		return o;
	endfunction

	// one bit of a restoring division, remainder and quotient packed
	function automatic logic [47:0] div_step(input logic [30:0] rem, input logic [16:0] q,
		input logic b, input logic [30:0] d);
		logic [31:0] r2;
		logic [30:0] rn;
		logic [16:0] qn;
		r2 = {rem, b};
		if (r2 >= {1'b0, d}) begin
			rn = 31'(r2 - {1'b0, d});
			qn = {q[15:0], 1'b1};
		end else begin
			rn = r2[30:0];
			qn = {q[15:0], 1'b0};
		end
		return {rn, qn};
	endfunction

endpackage

>>> rtl/box_circle_contact.sv
// top level of the box circle contact block
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | box_x box_y box_half_w box_half_h
//          |           |                         | circle_x circle_y radius
//  out     | output    | out_valid / out_ready   | overlap normal_x normal_y depth
//          |           |                         | point_x point_y
//
// one pair a cycle sustained while out_ready holds; a result passes through 2 more
// front stages after its transfer, the queue, 53 back stages and the output register
// the back end length is set by the 31 step square root and 17 step divider pipelines
// reset clears only valid flags and queue pointers, no warm-up pass
// an output stall freezes the back end; the front end keeps taking pairs until the
// queue fills, then in_ready drops
module box_circle_contact #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] box_x,
	input  logic signed [31:0] box_y,
	input  logic [29:0]        box_half_w,
	input  logic [29:0]        box_half_h,
	input  logic signed [31:0] circle_x,
	input  logic signed [31:0] circle_y,
	input  logic [29:0]        radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               overlap,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic [30:0]        depth,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y
);

	bcc_pkg::ent_t wdata, rdata;
	logic          push, full, pop, empty;

	bcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.box_x      (box_x),
		.box_y      (box_y),
		.box_half_w (box_half_w),
		.box_half_h (box_half_h),
		.circle_x   (circle_x),
		.circle_y   (circle_y),
		.radius     (radius),
		.push       (push),
		.wdata      (wdata),
		.full       (full)
	);

	bcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	bcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rdata     (rdata),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.overlap   (overlap),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.depth     (depth),
		.point_x   (point_x),
		.point_y   (point_y)
	);

endmodule

>>> rtl/bcc_front.sv
// front end: accepts pairs, clamps, squares and classifies them
module bcc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] box_x,
	input  logic signed [31:0] box_y,
	input  logic [29:0]        box_half_w,
	input  logic [29:0]        box_half_h,
	input  logic signed [31:0] circle_x,
	input  logic signed [31:0] circle_y,
	input  logic [29:0]        radius,
	output logic               push,
	output bcc_pkg::ent_t      wdata,
	input  logic               full
);

	localparam logic signed [33:0] P32MAX = 34'sd2147483647;
	localparam logic signed [33:0] P32MIN = -34'sd2147483648;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [31:0] bx_s1, by_s1, cx_s1, cy_s1;
	logic [29:0]        hw_s1, hh_s1, r_s1;

	logic signed [33:0] ex_s2, ey_s2, penx_s2, peny_s2;
	logic signed [31:0] px_s2, py_s2;
	logic               dxneg_s2, dyneg_s2;
	logic [29:0]        r_s2;

	logic               rej_s3;
	logic [59:0]        sqx_s3, sqy_s3, r2_s3;
	logic [29:0]        ax_s3, ay_s3, r_s3;
	logic               negx_s3, negy_s3;
	logic signed [17:0] nx_s3, ny_s3;
	logic [30:0]        dep_s3;
	logic signed [31:0] px_s3, py_s3;

	// stage 1 combinational
	logic signed [33:0] bx34, by34, cx34, cy34, hw34, hh34;
	logic signed [33:0] lox, hix, loy, hiy, pxw, pyw, dx, dy, adx, ady;
	logic signed [31:0] pxs, pys;

	always_comb begin
		bx34 = 34'(bx_s1);
		by34 = 34'(by_s1);
		cx34 = 34'(cx_s1);
		cy34 = 34'(cy_s1);
		hw34 = $signed({4'b0000, hw_s1});
		hh34 = $signed({4'b0000, hh_s1});
		lox  = bx34 - hw34;
		hix  = bx34 + hw34;
		loy  = by34 - hh34;
		hiy  = by34 + hh34;
		pxw  = (cx34 < lox) ? lox : ((cx34 > hix) ? hix : cx34);
		pyw  = (cy34 < loy) ? loy : ((cy34 > hiy) ? hiy : cy34);
		dx   = cx34 - bx34;
		dy   = cy34 - by34;
		adx  = (dx < 0) ? -dx : dx;
		ady  = (dy < 0) ? -dy : dy;
		pxs  = (pxw > P32MAX) ? P32MAX[31:0] : ((pxw < P32MIN) ? P32MIN[31:0] : pxw[31:0]);
		pys  = (pyw > P32MAX) ? P32MAX[31:0] : ((pyw < P32MIN) ? P32MIN[31:0] : pyw[31:0]);
	end

	// stage 2 combinational
	logic [33:0]        ax34, ay34;
	logic signed [33:0] pen;
	logic [31:0]        dep32;
	logic               pick_x;

	always_comb begin
		ax34   = (ex_s2 < 0) ? 34'(-ex_s2) : 34'(ex_s2);
		ay34   = (ey_s2 < 0) ? 34'(-ey_s2) : 34'(ey_s2);
		pick_x = penx_s2 < peny_s2;
		pen    = pick_x ? penx_s2 : peny_s2;
		if (pen < 0) begin
			pen = '0;
		end
		dep32 = 32'(r_s2) + 32'(pen[29:0]);
		if (dep32 > 32'h7FFFFFFF) begin
			dep32 = 32'h7FFFFFFF;
		end
	end

	// stage 3 combinational, queue write
	logic [60:0] s_sum;
	logic        ovl;

	always_comb begin
		s_sum = 61'(sqx_s3) + 61'(sqy_s3);
		ovl   = !rej_s3 && (s_sum < 61'(r2_s3));
		wdata.ax    = ax_s3;
		wdata.ay    = ay_s3;
		wdata.neg_x = negx_s3;
		wdata.neg_y = negy_s3;
		wdata.s     = s_sum;
		wdata.r     = r_s3;
		wdata.nx    = nx_s3;
		wdata.ny    = ny_s3;
		wdata.depth = dep_s3;
		wdata.px    = px_s3;
		wdata.py    = py_s3;
		if (!ovl) begin
			wdata.cls = bcc_pkg::CLS_NONE;
		end else if (s_sum == '0) begin
			wdata.cls = bcc_pkg::CLS_INSIDE;
		end else begin
			wdata.cls = bcc_pkg::CLS_EDGE;
		end
	end

	assign en       = !(v_s3 && full);
	assign in_ready = en;
	assign push     = v_s3 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s1 <= box_x;
			by_s1 <= box_y;
			hw_s1 <= box_half_w;
			hh_s1 <= box_half_h;
			cx_s1 <= circle_x;
			cy_s1 <= circle_y;
			r_s1  <= radius;

			ex_s2    <= cx34 - pxw;
			ey_s2    <= cy34 - pyw;
			penx_s2  <= hw34 - adx;
			peny_s2  <= hh34 - ady;
			px_s2    <= pxs;
			py_s2    <= pys;
			dxneg_s2 <= dx < 0;
			dyneg_s2 <= dy < 0;
			r_s2     <= r_s1;

			rej_s3  <= (ax34 >= 34'(r_s2)) || (ay34 >= 34'(r_s2));
			sqx_s3  <= ax34[29:0] * ax34[29:0];
			sqy_s3  <= ay34[29:0] * ay34[29:0];
			r2_s3   <= r_s2 * r_s2;
			ax_s3   <= ax34[29:0];
			ay_s3   <= ay34[29:0];
			negx_s3 <= ex_s2 < 0;
			negy_s3 <= ey_s2 < 0;
			r_s3    <= r_s2;
			nx_s3   <= pick_x ? (dxneg_s2 ? bcc_pkg::NORM_NEG : bcc_pkg::NORM_POS)
				: bcc_pkg::NORM_ZERO;
			ny_s3   <= pick_x ? bcc_pkg::NORM_ZERO
				: (dyneg_s2 ? bcc_pkg::NORM_NEG : bcc_pkg::NORM_POS);
			dep_s3  <= dep32[30:0];
			px_s3   <= px_s2;
			py_s3   <= py_s2;
		end
	end

endmodule

>>> rtl/bcc_queue.sv
// small queue between the front and back ends
`include "box_circle_contact_defines.svh"

module bcc_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bcc_pkg::ent_t wdata,
	output logic          full,
	input  logic          pop,
	output bcc_pkg::ent_t rdata,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bcc_pkg::ent_t  mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	`BCC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH), "queue count beyond depth")
	`BCC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count not raised")
	`BCC_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue count not lowered")

endmodule

>>> rtl/bcc_back.sv
// back end: normalise, square roots, divisions and the output register
`include "box_circle_contact_defines.svh"

module bcc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bcc_pkg::ent_t      rdata,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               overlap,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic [30:0]        depth,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y
);

	localparam int ST_SHIFT = 1;
	localparam int ST_SQ    = 2;
	localparam int ST_SUM   = 3;
	localparam int ST_ROOT0 = 4;
	localparam int ST_PREP  = ST_ROOT0 + bcc_pkg::SQ_STEPS;
	localparam int ST_DIV0  = ST_PREP + 1;
	localparam int NST      = ST_DIV0 + bcc_pkg::DIV_STEPS;

	bcc_pkg::bst_t st_q  [NST];
	bcc_pkg::bst_t nxt   [NST];
	logic          vld_q [NST];
	logic          en;

	logic               out_valid_q, overlap_q;
	logic signed [17:0] normal_x_q, normal_y_q;
	logic [30:0]        depth_q;
	logic signed [31:0] point_x_q, point_y_q;

	logic [29:0] m;
	logic [4:0]  lz;

	always_comb begin
		m  = (rdata.ax > rdata.ay) ? rdata.ax : rdata.ay;
		lz = '0;
		for (int i = 0; i < 30; i++) begin
			if (m[i]) begin
				lz = 5'(29 - i);
			end
		end
	end

	always_comb begin
		logic [61:0] va;
		logic [61:0] vb;
		logic [47:0] dxr;
		logic [47:0] dyr;
		int k;
		int j;
		nxt[0]    = '0;
		nxt[0].pl = rdata;
		nxt[0].lz = lz;
		for (int i = 1; i < NST; i++) begin
			nxt[i] = st_q[i-1];
			va = {1'b0, st_q[i-1].vn};
			vb = {1'b0, st_q[i-1].pl.s};
			k  = i - ST_ROOT0;
			j  = i - ST_DIV0;
			if (i == ST_SHIFT) begin
				nxt[i].axn = st_q[i-1].pl.ax << st_q[i-1].lz;
				nxt[i].ayn = st_q[i-1].pl.ay << st_q[i-1].lz;
			end else if (i == ST_SQ) begin
				nxt[i].sqx = st_q[i-1].axn * st_q[i-1].axn;
				nxt[i].sqy = st_q[i-1].ayn * st_q[i-1].ayn;
			end else if (i == ST_SUM) begin
				nxt[i].vn = 61'(st_q[i-1].sqx) + 61'(st_q[i-1].sqy);
			end else if (i >= ST_ROOT0 && i < ST_PREP) begin
				nxt[i].ra = bcc_pkg::sq_step(st_q[i-1].ra, va[61-2*k -: 2]);
				nxt[i].rb = bcc_pkg::sq_step(st_q[i-1].rb, vb[61-2*k -: 2]);
			end else if (i == ST_PREP) begin
				nxt[i].nnx  = {1'b0, st_q[i-1].axn, 16'd0} + 47'(st_q[i-1].ra.root >> 1);
				nxt[i].nny  = {1'b0, st_q[i-1].ayn, 16'd0} + 47'(st_q[i-1].ra.root >> 1);
				nxt[i].remx = 31'(nxt[i].nnx[46:17]);
				nxt[i].remy = 31'(nxt[i].nny[46:17]);
				nxt[i].qx   = '0;
				nxt[i].qy   = '0;
			end else if (i >= ST_DIV0) begin
				dxr = bcc_pkg::div_step(st_q[i-1].remx, st_q[i-1].qx,
					st_q[i-1].nnx[16-j], st_q[i-1].ra.root);
				dyr = bcc_pkg::div_step(st_q[i-1].remy, st_q[i-1].qy,
					st_q[i-1].nny[16-j], st_q[i-1].ra.root);
				nxt[i].remx = dxr[47:17];
				nxt[i].qx   = dxr[16:0];
				nxt[i].remy = dyr[47:17];
				nxt[i].qy   = dyr[16:0];
			end
		end
	end

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				vld_q[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= !empty;
			for (int i = 1; i < NST; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			out_valid_q <= vld_q[NST-1];
		end
	end

	bcc_pkg::bst_t      fin;
	logic signed [17:0] qxs, qys;

	always_comb begin
		fin = st_q[NST-1];
		qxs = $signed({1'b0, fin.qx});
		qys = $signed({1'b0, fin.qy});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) begin
				st_q[i] <= nxt[i];
			end
			case (fin.pl.cls)
				bcc_pkg::CLS_EDGE: begin
					overlap_q  <= 1'b1;
					normal_x_q <= fin.pl.neg_x ? -qxs : qxs;
					normal_y_q <= fin.pl.neg_y ? -qys : qys;
					depth_q    <= 31'(fin.pl.r) - fin.rb.root;
					point_x_q  <= fin.pl.px;
					point_y_q  <= fin.pl.py;
				end
				bcc_pkg::CLS_INSIDE: begin
					overlap_q  <= 1'b1;
					normal_x_q <= fin.pl.nx;
					normal_y_q <= fin.pl.ny;
					depth_q    <= fin.pl.depth;
					point_x_q  <= fin.pl.px;
					point_y_q  <= fin.pl.py;
				end
				default: begin
					overlap_q  <= 1'b0;
					normal_x_q <= '0;
					normal_y_q <= '0;
					depth_q    <= '0;
					point_x_q  <= '0;
					point_y_q  <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign overlap   = overlap_q;
	assign normal_x  = normal_x_q;
	assign normal_y  = normal_y_q;
	assign depth     = depth_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;

	`BCC_ASSERT_IMP(a_none_zero, out_valid_q && !overlap_q,
		normal_x_q == '0 && normal_y_q == '0 && depth_q == '0, "no-overlap result not zero")
	`BCC_ASSERT_IMP(a_hit_depth, out_valid_q && overlap_q, depth_q != '0, "overlap with zero depth")
	`BCC_ASSERT_IMP(a_norm_range, out_valid_q && overlap_q,
		normal_x_q <= bcc_pkg::NORM_POS && normal_x_q >= -bcc_pkg::NORM_POS &&
		normal_y_q <= bcc_pkg::NORM_POS && normal_y_q >= -bcc_pkg::NORM_POS,
		"normal component out of range")

endmodule
